FILE: hdl/mrc_pkg.sv
// Shared types and constants for the Modbus RTU response checker.
package mrc_pkg;

    // Register store geometry.
    localparam int MAX_REGISTERS = 32;
    localparam int RA_W          = $clog2(MAX_REGISTERS);

    // CRC-16 constants (reflected polynomial).
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Frame constants.
    localparam logic [7:0] FUNC_READ_INPUT = 8'h04;
    localparam int         EXC_BIT         = 7;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SLAVE_ADDRESS  = 2'd0;
    localparam logic [1:0] CFG_REGISTER_COUNT = 2'd1;
    localparam logic [1:0] CFG_MIN_REGISTERS  = 2'd2;

    // Result word kinds.
    localparam logic KIND_REGISTER = 1'b0;
    localparam logic KIND_STATUS   = 1'b1;

    // Frame status codes.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_CRC       = 3'd1,
        ST_SLAVE     = 3'd2,
        ST_EXCEPTION = 3'd3,
        ST_FUNCTION  = 3'd4,
        ST_FEW_REGS  = 3'd5
    } t_status;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CRC,
        S_EVAL,
        S_RD_ADDR,
        S_RD_DATA,
        S_FINAL
    } t_state;

    // Control from the sequencer to the CRC unit.
    typedef struct packed {
        logic       clear;
        logic       start;
        logic [7:0] data;
    } t_crc_ctrl;

    // Status from the CRC unit back to the sequencer.
    typedef struct packed {
        logic        busy;
        logic        done;
        logic [15:0] crc;
    } t_crc_stat;

endpackage

FILE: hdl/mrc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mrc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/mrc_crc.sv
// Bit-serial CRC-16 unit: one shift and conditional XOR per cycle.
module mrc_crc (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mrc_pkg::t_crc_ctrl    i_ctrl,
    output mrc_pkg::t_crc_stat    o_stat
);
    import mrc_pkg::*;

    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic [2:0]  r_bit;
    logic        r_busy;

    // One step of the reflected CRC shift register.
    always_comb begin
        if (r_crc[0]) begin
            n_crc = (r_crc >> 1) ^ CRC_POLY;
        end else begin
            n_crc = r_crc >> 1;
        end
    end

    // The byte is folded in on start, then eight shift steps follow.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_crc  <= CRC_INIT;
            r_bit  <= '0;
            r_busy <= 1'b0;
        end else if (i_ctrl.start) begin
            r_crc  <= r_crc ^ {8'h00, i_ctrl.data};
            r_bit  <= '0;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_crc <= n_crc;
            r_bit <= r_bit + 3'd1;
            if (r_bit == 3'd7) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_busy && (r_bit == 3'd7);
    assign o_stat.crc  = r_crc;

`ifndef SYNTH
    // A started byte always finishes its eight shift steps.
    a_crc_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.start && !i_ctrl.clear) |=> ##7 o_stat.done)
        else $error("CRC unit did not finish a byte in eight steps");
`endif

endmodule

FILE: hdl/modbus_rtu_response_checker.sv
// Top level: Modbus RTU read-input-registers response checker.
// Flow: each byte is taken in the idle state; once the frame is past its second byte,
// the bit-serial CRC unit works through it before the next byte is taken. The
// end-of-frame byte leads to an evaluation state, then per register word a store read
// and a load, then the status word; each load waits while the output is held.
// Reset (synchronous, active low) restores the configuration defaults and clears the
// frame state; the register store is not cleared, only words written this frame are read.
module modbus_rtu_response_checker #(
    parameter int MAX_FRAME_BYTES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // Byte input channel.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_end_of_frame,
    // Result channel.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_item_kind,
    output logic [2:0]  o_status,
    output logic [4:0]  o_register_index,
    output logic [15:0] o_register_value,
    output logic [7:0]  o_exception_code,
    output logic        o_byte_count_mismatch,
    output logic [5:0]  o_registers_received,
    output logic        o_last
);
    import mrc_pkg::*;

    localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
    localparam int KW = CW + RA_W;

    // Configuration registers.
    logic [7:0] r_slave;
    logic [5:0] r_reg_count;
    logic [5:0] r_min_regs;

    // Frame state.
    t_state      r_state;
    t_state      n_state;
    logic [CW-1:0] r_cnt;
    logic [7:0]  r_dly [2];
    logic [7:0]  r_hdr [3];
    logic [7:0]  r_hold;
    logic        r_eof;

    // Evaluation results.
    t_status     r_status;
    logic [5:0]  r_avail;
    logic        r_mis;
    logic [RA_W-1:0] r_idx;

    // Output word register.
    logic        r_out_valid;
    logic        r_kind;
    t_status     r_out_status;
    logic [4:0]  r_out_idx;
    logic [15:0] r_out_value;
    logic [7:0]  r_out_exc;
    logic        r_out_mis;
    logic [5:0]  r_out_avail;
    logic        r_out_last;

    // Handshakes and byte position decode.
    logic        w_in_acc;
    logic        w_out_free;
    logic        w_in_range;
    logic        w_feed;
    logic [KW-1:0] w_k;
    logic [KW-2:0] w_r;
    logic        w_ram_we;
    logic        w_ram_re;
    logic [15:0] w_ram_rdata;
    logic        w_load_reg;
    logic        w_load_final;

    // Evaluation logic.
    t_status     w_status;
    logic [CW-1:0] w_raw;
    logic [5:0]  w_avail;
    logic        w_mis;
    logic [RA_W:0] w_idx_next;

    t_crc_ctrl   w_crc_ctrl;
    t_crc_stat   w_crc_stat;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // Position of the incoming byte within the frame.
    assign w_in_range = r_cnt < CW'(MAX_FRAME_BYTES);
    assign w_feed     = w_in_range && (r_cnt >= CW'(2));
    assign w_k        = KW'(r_cnt) - KW'(3);
    assign w_r        = w_k[KW-1:1];
    assign w_ram_we   = w_in_acc && w_in_range && (r_cnt >= CW'(3)) && w_k[0]
                        && (KW'(w_r) < KW'(MAX_REGISTERS));

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave     <= 8'd1;
            r_reg_count <= 6'd5;
            r_min_regs  <= 6'd5;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SLAVE_ADDRESS:  r_slave     <= i_cfg_data;
                CFG_REGISTER_COUNT: r_reg_count <= i_cfg_data[5:0];
                CFG_MIN_REGISTERS:  r_min_regs  <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // CRC unit.
    assign w_crc_ctrl.clear = w_load_final;
    assign w_crc_ctrl.start = w_in_acc && w_feed;
    assign w_crc_ctrl.data  = r_dly[0];

    mrc_crc u_crc (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctrl (w_crc_ctrl),
        .o_stat (w_crc_stat)
    );

    // Register store.
    mrc_ram #(
        .WIDTH(16),
        .DEPTH(MAX_REGISTERS)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_waddr(w_r[RA_W-1:0]),
        .i_wdata({r_hold, i_rx_byte}),
        .i_re   (w_ram_re),
        .i_raddr(r_idx),
        .o_rdata(w_ram_rdata)
    );

    // Frame status, checked in priority order.
    always_comb begin
        w_raw   = (r_cnt >= CW'(5)) ? CW'((r_cnt - CW'(5)) >> 1) : '0;
        w_avail = 6'(w_raw);
        if (16'(w_raw) > 16'(r_reg_count)) begin
            w_avail = r_reg_count;
        end
        if (16'(w_avail) > 16'(MAX_REGISTERS)) begin
            w_avail = 6'(MAX_REGISTERS);
        end
        w_mis = r_hdr[2] != {1'b0, r_reg_count, 1'b0};
        priority if (r_cnt < CW'(4) || {r_dly[1], r_dly[0]} != w_crc_stat.crc) begin
            w_status = ST_CRC;
        end else if (r_hdr[0] != r_slave) begin
            w_status = ST_SLAVE;
        end else if (r_hdr[1][EXC_BIT]) begin
            w_status = ST_EXCEPTION;
        end else if (r_hdr[1] != FUNC_READ_INPUT) begin
            w_status = ST_FUNCTION;
        end else if (w_avail >= r_min_regs) begin
            w_status = ST_OK;
        end else begin
            w_status = ST_FEW_REGS;
        end
    end

    assign w_idx_next = {1'b0, r_idx} + 1'b1;

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer next state and strobes.
    always_comb begin
        n_state      = r_state;
        w_ram_re     = 1'b0;
        w_load_reg   = 1'b0;
        w_load_final = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (w_feed) begin
                        n_state = S_CRC;
                    end else if (i_end_of_frame) begin
                        n_state = S_EVAL;
                    end
                end
            end
            S_CRC: begin
                if (w_crc_stat.done) begin
                    n_state = r_eof ? S_EVAL : S_IDLE;
                end
            end
            S_EVAL: begin
                if (w_status == ST_OK && w_avail != 6'd0) begin
                    n_state = S_RD_ADDR;
                end else begin
                    n_state = S_FINAL;
                end
            end
            S_RD_ADDR: begin
                w_ram_re = 1'b1;
                n_state  = S_RD_DATA;
            end
            S_RD_DATA: begin
                if (w_out_free) begin
                    w_load_reg = 1'b1;
                    n_state    = (6'(w_idx_next) == r_avail) ? S_FINAL : S_RD_ADDR;
                end
            end
            S_FINAL: begin
                if (w_out_free) begin
                    w_load_final = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Frame capture: delay line, header, high byte, byte count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_load_final) begin
            r_cnt  <= '0;
            r_dly  <= '{default: '0};
            r_hdr  <= '{default: '0};
            r_hold <= '0;
            r_eof  <= 1'b0;
        end else if (w_in_acc) begin
            r_eof <= i_end_of_frame;
            if (w_in_range) begin
                r_dly[0] <= r_dly[1];
                r_dly[1] <= i_rx_byte;
                if (r_cnt < CW'(3)) begin
                    r_hdr[r_cnt[1:0]] <= i_rx_byte;
                end else if (!w_k[0]) begin
                    r_hold <= i_rx_byte;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // Evaluation results and register read pointer.
    always_ff @(posedge i_clk) begin
        if (r_state == S_EVAL) begin
            r_status <= w_status;
            r_avail  <= (w_status == ST_OK || w_status == ST_FEW_REGS) ? w_avail : 6'd0;
            r_mis    <= (w_status == ST_OK || w_status == ST_FEW_REGS) ? w_mis : 1'b0;
            r_idx    <= '0;
        end else if (w_load_reg) begin
            r_idx <= w_idx_next[RA_W-1:0];
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_reg || w_load_final) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_reg) begin
            r_kind       <= KIND_REGISTER;
            r_out_status <= ST_OK;
            r_out_idx    <= 5'(r_idx);
            r_out_value  <= w_ram_rdata;
            r_out_exc    <= r_hdr[2];
            r_out_mis    <= r_mis;
            r_out_avail  <= r_avail;
            r_out_last   <= 1'b0;
        end else if (w_load_final) begin
            r_kind       <= KIND_STATUS;
            r_out_status <= r_status;
            r_out_idx    <= '0;
            r_out_value  <= '0;
            r_out_exc    <= r_hdr[2];
            r_out_mis    <= r_mis;
            r_out_avail  <= r_avail;
            r_out_last   <= 1'b1;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_item_kind           = r_kind;
    assign o_status              = r_out_status;
    assign o_register_index      = r_out_idx;
    assign o_register_value      = r_out_value;
    assign o_exception_code      = r_out_exc;
    assign o_byte_count_mismatch = r_out_mis;
    assign o_registers_received  = r_out_avail;
    assign o_last                = r_out_last;

`ifndef SYNTH
    // Only the status word closes a frame.
    a_last_is_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last == (o_item_kind == KIND_STATUS)))
        else $error("Last flag does not match the word kind");

    // Register words appear only for a good frame and stay within the count.
    a_reg_word_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_item_kind == KIND_REGISTER) |->
        (o_status == ST_OK && 6'(o_register_index) < o_registers_received))
        else $error("Register word outside a good frame or past the count");

    // Bytes are taken only while the CRC unit is idle.
    a_ready_crc_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_crc_stat.busy)
        else $error("Byte input ready while the CRC unit is busy");

    // A frame is cleared once its status word is loaded.
    a_frame_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_final |=> (r_cnt == '0 && r_state == S_IDLE))
        else $error("Frame state not cleared after the status word");
`endif

endmodule
